[rtl/assert_macros.svh]
// Assertion macros used by the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that holds at every clock edge outside reset
`define BTRAIL_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication
`define BTRAIL_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define BTRAIL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/btrail_pkg.sv]
// Shared types, constants and helper function of the undo trail unit.
package btrail_pkg;

    // Trail sizing
    localparam int TRAIL_DEPTH = 64;
    localparam int ADDR_W      = $clog2(TRAIL_DEPTH);
    localparam int DEPTH_W     = $clog2(TRAIL_DEPTH + 1);
    localparam int BASE_W      = 7;

    // Table limits per record kind
    localparam logic [8:0] LOOP_LIMIT     = 9'd32;
    localparam logic [8:0] CAPTURE_LIMIT  = 9'd32;
    localparam logic [8:0] VARIABLE_LIMIT = 9'd32;

    // Opcodes
    localparam logic [2:0] OP_PUSH_COUNTER  = 3'd0;
    localparam logic [2:0] OP_PUSH_CAPTURE  = 3'd1;
    localparam logic [2:0] OP_PUSH_VARIABLE = 3'd2;
    localparam logic [2:0] OP_REPLAY        = 3'd3;
    localparam logic [2:0] OP_CLEAR         = 3'd4;

    // Record kinds
    localparam logic [1:0] KIND_NONE     = 2'd0;
    localparam logic [1:0] KIND_COUNTER  = 2'd1;
    localparam logic [1:0] KIND_CAPTURE  = 2'd2;
    localparam logic [1:0] KIND_VARIABLE = 2'd3;

    // Half selectors
    localparam logic [1:0] WHICH_START = 2'd0;
    localparam logic [1:0] WHICH_END   = 2'd1;
    localparam logic [1:0] WHICH_BOTH  = 2'd2;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  reg_index;
        logic [1:0]  which_half;
        logic [31:0] old_start;
        logic [31:0] old_end;
        logic [31:0] old_count;
        logic [31:0] old_last_pos;
        logic [6:0]  base_depth;
    } item_t;

    typedef struct packed {
        logic [1:0]  restore_kind;
        logic [7:0]  restore_index;
        logic [1:0]  restore_which;
        logic [31:0] value_a;
        logic [31:0] value_b;
        logic        apply;
        logic        last;
        logic [6:0]  depth_now;
        logic        dropped;
    } result_t;

    // One trail record as stored in memory
    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  which;
        logic [7:0]  index;
        logic [31:0] value_a;
        logic [31:0] value_b;
    } record_t;

    // Memory access request from the controller
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        record_t           wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    typedef enum logic {
        ST_IDLE,
        ST_REPLAY
    } state_t;

    // Index lies inside the table of its kind
    function automatic logic apply_of(logic [1:0] kind, logic [7:0] index);
        logic [8:0] idx9;
        logic       ok;
        idx9 = {1'b0, index};
        case (kind)
            KIND_COUNTER:  ok = (idx9 < LOOP_LIMIT);
            KIND_CAPTURE:  ok = (idx9 < CAPTURE_LIMIT);
            KIND_VARIABLE: ok = (idx9 < VARIABLE_LIMIT);
            default:       ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

[rtl/btrail_ram.sv]
// Trail record memory: one write port, one registered read port.
module btrail_ram
(
    input  logic                clk,
    input  btrail_pkg::ram_req_t req,
    output btrail_pkg::record_t  rdata
);

    btrail_pkg::record_t mem [btrail_pkg::TRAIL_DEPTH];
    btrail_pkg::record_t rdata_reg;

    // Write and registered read; read data holds when no read is issued
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/btrail_ctrl.sv]
// Trail controller: depth tracking, push writes, replay pops and result register.
module btrail_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  btrail_pkg::item_t    item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output btrail_pkg::result_t  result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data,
    output btrail_pkg::ram_req_t ram_req,
    input  btrail_pkg::record_t  ram_rdata
);

    localparam int DW = btrail_pkg::DEPTH_W;
    localparam int AW = btrail_pkg::ADDR_W;
    localparam int BW = btrail_pkg::BASE_W;

    btrail_pkg::state_t  state_reg, state_next;
    logic                enable_reg, enable_next;
    logic [DW-1:0]       depth_reg, depth_next;
    logic [DW-1:0]       iss_reg, iss_next;
    logic [DW-1:0]       base_reg, base_next;
    logic                pend_reg, pend_next;
    logic                pend_last_reg, pend_last_next;
    logic                out_valid_reg, out_valid_next;
    btrail_pkg::result_t out_data_reg, out_data_next;

    logic          accept;
    logic          out_free;
    logic          move;
    logic          issue;
    logic [DW-1:0] iss_dec;
    logic          is_push;
    logic          full;
    logic          do_write;
    logic          replay_go;
    logic [1:0]    push_which;
    btrail_pkg::record_t push_rec;
    btrail_pkg::result_t empty_res;

    // Handshake and pipeline control
    assign accept   = item_valid && item_ready;
    assign out_free = !out_valid_reg || result_ready;
    assign move     = pend_reg && out_free;
    assign iss_dec  = iss_reg - DW'(1);
    assign issue    = (state_reg == btrail_pkg::ST_REPLAY) && (iss_reg > base_reg)
                      && (!pend_reg || move);

    // Decode of the accepted item
    assign is_push   = (item.opcode == btrail_pkg::OP_PUSH_COUNTER)
                    || (item.opcode == btrail_pkg::OP_PUSH_CAPTURE)
                    || (item.opcode == btrail_pkg::OP_PUSH_VARIABLE);
    assign full      = (depth_reg >= DW'(btrail_pkg::TRAIL_DEPTH));
    assign do_write  = accept && is_push && enable_reg && !full;
    assign replay_go = accept && (item.opcode == btrail_pkg::OP_REPLAY)
                    && (item.base_depth < BW'(depth_reg));

    // Record built from a push
    always_comb
    begin
        if (item.opcode == btrail_pkg::OP_PUSH_CAPTURE)
        begin
            push_which = (item.which_half > btrail_pkg::WHICH_BOTH)
                       ? btrail_pkg::WHICH_BOTH : item.which_half;
        end
        else
        begin
            push_which = btrail_pkg::WHICH_BOTH;
        end
        push_rec.which = push_which;
        push_rec.index = item.reg_index;
        case (item.opcode)
            btrail_pkg::OP_PUSH_COUNTER:
            begin
                push_rec.kind    = btrail_pkg::KIND_COUNTER;
                push_rec.value_a = item.old_last_pos;
                push_rec.value_b = item.old_count;
            end
            btrail_pkg::OP_PUSH_CAPTURE:
            begin
                push_rec.kind    = btrail_pkg::KIND_CAPTURE;
                push_rec.value_a = item.old_start;
                push_rec.value_b = item.old_end;
            end
            default:
            begin
                push_rec.kind    = btrail_pkg::KIND_VARIABLE;
                push_rec.value_a = item.old_start;
                push_rec.value_b = item.old_end;
            end
        endcase
    end

    // Memory requests
    assign ram_req.we    = do_write;
    assign ram_req.waddr = depth_reg[AW-1:0];
    assign ram_req.wdata = push_rec;
    assign ram_req.re    = issue;
    assign ram_req.raddr = iss_dec[AW-1:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            btrail_pkg::ST_IDLE:
            begin
                if (replay_go)
                begin
                    state_next = btrail_pkg::ST_REPLAY;
                end
            end
            btrail_pkg::ST_REPLAY:
            begin
                if (move && pend_last_reg)
                begin
                    state_next = btrail_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = btrail_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        case (state_reg)
            btrail_pkg::ST_IDLE:   item_ready = out_free;
            btrail_pkg::ST_REPLAY: item_ready = 1'b0;
            default:               item_ready = 1'b0;
        endcase
    end

    // Depth, replay counters and pending read
    always_comb
    begin
        depth_next     = depth_reg;
        iss_next       = iss_reg;
        base_next      = base_reg;
        pend_next      = pend_reg;
        pend_last_next = pend_last_reg;
        enable_next    = (cfg_valid && cfg_ready) ? cfg_data : enable_reg;

        if (do_write)
        begin
            depth_next = depth_reg + DW'(1);
        end
        else if (replay_go)
        begin
            depth_next = DW'(item.base_depth);
            base_next  = DW'(item.base_depth);
            iss_next   = depth_reg;
        end
        else if (accept && (item.opcode == btrail_pkg::OP_CLEAR))
        begin
            depth_next = '0;
        end

        if (issue)
        begin
            iss_next       = iss_dec;
            pend_next      = 1'b1;
            pend_last_next = (iss_dec == base_reg);
        end
        else if (move)
        begin
            pend_next = 1'b0;
        end
    end

    // Result register
    always_comb
    begin
        empty_res               = '0;
        empty_res.restore_kind  = btrail_pkg::KIND_NONE;
        empty_res.last          = 1'b1;
        empty_res.depth_now     = 7'(depth_next);
        empty_res.dropped       = accept && is_push && enable_reg && full;

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (move)
        begin
            out_valid_next              = 1'b1;
            out_data_next.restore_kind  = ram_rdata.kind;
            out_data_next.restore_index = ram_rdata.index;
            out_data_next.restore_which = ram_rdata.which;
            out_data_next.value_a       = ram_rdata.value_a;
            out_data_next.value_b       = ram_rdata.value_b;
            out_data_next.apply         = btrail_pkg::apply_of(ram_rdata.kind,
                                                               ram_rdata.index);
            out_data_next.last          = pend_last_reg;
            out_data_next.depth_now     = 7'(depth_reg);
            out_data_next.dropped       = 1'b0;
        end
        else if (accept && !replay_go)
        begin
            out_valid_next = 1'b1;
            out_data_next  = empty_res;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= btrail_pkg::ST_IDLE;
            enable_reg    <= 1'b0;
            depth_reg     <= '0;
            iss_reg       <= '0;
            base_reg      <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            enable_reg    <= enable_next;
            depth_reg     <= depth_next;
            iss_reg       <= iss_next;
            base_reg      <= base_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign cfg_ready    = 1'b1;
    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

endmodule

[rtl/backtrack_undo_trail_unit.sv]
// Undo trail unit: record memory plus controller, with interface checks.
//
// Usage:
//   item channel (item_valid/item_ready/item) takes push, replay and clear
//   transactions. result channel (result_valid/result_ready/result) returns
//   restore results; result.last marks the final one of each transaction.
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes trail_enable at any
//   time the block is idle; cfg_ready is always high.
// Throughput:
//   push, clear and no-op transactions give one result in the cycle after
//   acceptance; one such transaction per cycle while results are taken.
//   A replay that pops N records gives its first result via the state,
//   memory read and result registers, then one per cycle while results are
//   taken, one memory read per record; no new item until the last is out.
// Reset:
//   rst_n clears depth, enable and all handshake state; the record memory
//   is not cleared and needs no clearing pass.
// Receiver stall:
//   the result register holds; a replay pauses with one record parked in
//   the memory read register, and no new item is taken until it drains.
`include "assert_macros.svh"

module backtrack_undo_trail_unit
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  btrail_pkg::item_t   item,
    output logic                result_valid,
    input  logic                result_ready,
    output btrail_pkg::result_t result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data
);

    btrail_pkg::ram_req_t ram_req;
    btrail_pkg::record_t  ram_rdata;

    logic single_take;
    logic single_out;
    logic empty_out;

    btrail_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .ram_req      (ram_req),
        .ram_rdata    (ram_rdata)
    );

    btrail_ram u_ram
    (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    // Terms used by the checks
    assign single_take = item_valid && item_ready && (item.opcode != btrail_pkg::OP_REPLAY);
    assign single_out  = result_valid && result.last;
    assign empty_out   = result_valid && (result.restore_kind == btrail_pkg::KIND_NONE);

    // Checks
    `BTRAIL_ASSERT_ALWAYS(a_no_rw_overlap, !(ram_req.we && ram_req.re), "write and read overlap")
    `BTRAIL_ASSERT_IMPL(a_no_read_when_open, item_ready, !ram_req.re, "read while taking items")
    `BTRAIL_ASSERT_NEXT(a_single_result, single_take, single_out, "missing single result")
    `BTRAIL_ASSERT_IMPL(a_empty_result, empty_out, result.last && !result.apply, "bad empty result")

endmodule

[test/backtrack_undo_trail_unit_tb.sv]
// Testbench for the undo trail unit: directed and random push/replay/clear traffic.
module backtrack_undo_trail_unit_tb;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int QUIET_WAIT   = 4;
    localparam int RANDOM_ITEMS = 380;
    localparam int HOLDOFF_AT   = 150;
    localparam int HOLDOFF_LEN  = 300;
    localparam int TAIL_CYCLES  = 10;

    typedef enum logic [1:0] {
        STEP_ITEM,
        STEP_CFG,
        STEP_DRAIN
    } step_kind_t;

    typedef struct {
        step_kind_t        kind;
        btrail_pkg::item_t payload;
        logic              cfg_value;
    } sender_step_t;

    logic                clk;
    logic                rst_n;
    logic                item_valid   = 1'b0;
    logic                item_ready;
    btrail_pkg::item_t   item_bus     = '0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    btrail_pkg::result_t result_bus;
    logic                cfg_valid    = 1'b0;
    logic                cfg_ready;
    logic                cfg_data     = 1'b0;

    backtrack_undo_trail_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item_bus),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result_bus),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    // Stimulus plan and its bookkeeping
    sender_step_t pending_steps[$];
    int           gen_depth;
    logic         gen_enable;
    int           planned_count;

    // Shadow of the trail used for prediction
    btrail_pkg::record_t saved_records [btrail_pkg::TRAIL_DEPTH];
    int                  trail_fill;
    logic                trail_on;
    btrail_pkg::result_t expected_restores[$];

    int           fail_count;
    int           items_accepted;
    int           cycle_count;
    int           quiet_cycles;
    int           gap_left;
    int           burst_left;
    int           holdoff_left;
    logic         holdoff_done;
    int           stall_mode;
    int           mode_left;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Reset, held low from the start
    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Bias the index around the table limits
    function automatic logic [7:0] rand_index();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(0, 31));
            1:       return 8'($urandom_range(32, 255));
            2:       return ($urandom_range(0, 1) != 0) ? 8'd31 : 8'd32;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic btrail_pkg::item_t rand_item(logic [2:0] op);
        btrail_pkg::item_t it;
        it.opcode       = op;
        it.reg_index    = rand_index();
        it.which_half   = 2'($urandom_range(0, 3));
        it.old_start    = rand_word();
        it.old_end      = rand_word();
        it.old_count    = rand_word();
        it.old_last_pos = rand_word();
        it.base_depth   = 7'($urandom_range(0, 127));
        return it;
    endfunction

    function automatic btrail_pkg::item_t make_replay(int base);
        btrail_pkg::item_t it;
        it            = rand_item(btrail_pkg::OP_REPLAY);
        it.base_depth = 7'(base);
        return it;
    endfunction

    function automatic btrail_pkg::item_t make_push(logic [2:0] op, logic [7:0] idx,
                                                    logic [1:0] half, logic [31:0] va,
                                                    logic [31:0] vb);
        btrail_pkg::item_t it;
        it              = rand_item(op);
        it.reg_index    = idx;
        it.which_half   = half;
        it.old_start    = va;
        it.old_end      = vb;
        it.old_last_pos = va;
        it.old_count    = vb;
        return it;
    endfunction

    // Queue one transaction and track the depth it leaves behind
    function automatic void queue_item(btrail_pkg::item_t it);
        sender_step_t s;
        s.kind      = STEP_ITEM;
        s.payload   = it;
        s.cfg_value = 1'b0;
        pending_steps.push_back(s);
        planned_count++;
        if (it.opcode <= btrail_pkg::OP_PUSH_VARIABLE)
        begin
            if (gen_enable && gen_depth < btrail_pkg::TRAIL_DEPTH)
                gen_depth++;
        end
        else
        begin
            if (it.opcode == btrail_pkg::OP_REPLAY && int'(it.base_depth) < gen_depth)
                gen_depth = int'(it.base_depth);
            else if (it.opcode == btrail_pkg::OP_CLEAR)
                gen_depth = 0;
        end
    endfunction

    function automatic void queue_cfg(logic value);
        sender_step_t s;
        s.kind      = STEP_CFG;
        s.payload   = '0;
        s.cfg_value = value;
        pending_steps.push_back(s);
        gen_enable = value;
    endfunction

    function automatic void queue_drain();
        sender_step_t s;
        s.kind      = STEP_DRAIN;
        s.payload   = '0;
        s.cfg_value = 1'b0;
        pending_steps.push_back(s);
    endfunction

    // Fill the trail, overflow it a little, then unwind
    function automatic void fill_trail();
        if (!gen_enable)
            queue_cfg(1'b1);
        while (gen_depth < btrail_pkg::TRAIL_DEPTH)
            queue_item(rand_item(3'($urandom_range(0, 2))));
        repeat ($urandom_range(1, 3)) queue_item(rand_item(3'($urandom_range(0, 2))));
        queue_item(make_replay($urandom_range(0, 16)));
    endfunction

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic logic [8:0] limit_for(logic [1:0] kind);
        case (kind)
            btrail_pkg::KIND_COUNTER:  return btrail_pkg::LOOP_LIMIT;
            btrail_pkg::KIND_CAPTURE:  return btrail_pkg::CAPTURE_LIMIT;
            btrail_pkg::KIND_VARIABLE: return btrail_pkg::VARIABLE_LIMIT;
            default:                   return 9'd0;
        endcase
    endfunction

    function automatic btrail_pkg::result_t status_result(int depth, logic drop);
        btrail_pkg::result_t r;
        r           = '0;
        r.last      = 1'b1;
        r.depth_now = 7'(depth);
        r.dropped   = drop;
        return r;
    endfunction

    task automatic predict_restores(input btrail_pkg::item_t it);
        btrail_pkg::record_t rec;
        btrail_pkg::result_t r;
        int                  pos;
        case (it.opcode)
            btrail_pkg::OP_PUSH_COUNTER, btrail_pkg::OP_PUSH_CAPTURE,
            btrail_pkg::OP_PUSH_VARIABLE:
            begin
                if (trail_on && trail_fill >= btrail_pkg::TRAIL_DEPTH)
                begin
                    expected_restores.push_back(status_result(trail_fill, 1'b1));
                end
                else
                begin
                    if (trail_on)
                    begin
                        rec.index = it.reg_index;
                        if (it.opcode == btrail_pkg::OP_PUSH_COUNTER)
                        begin
                            rec.kind    = btrail_pkg::KIND_COUNTER;
                            rec.which   = btrail_pkg::WHICH_BOTH;
                            rec.value_a = it.old_last_pos;
                            rec.value_b = it.old_count;
                        end
                        else
                        begin
                            rec.kind    = (it.opcode == btrail_pkg::OP_PUSH_CAPTURE)
                                        ? btrail_pkg::KIND_CAPTURE
                                        : btrail_pkg::KIND_VARIABLE;
                            rec.which   = btrail_pkg::WHICH_BOTH;
                            // start-only and end-only apply to captures alone
                            if (it.opcode == btrail_pkg::OP_PUSH_CAPTURE
                                && it.which_half < btrail_pkg::WHICH_BOTH)
                                rec.which = it.which_half;
                            rec.value_a = it.old_start;
                            rec.value_b = it.old_end;
                        end
                        saved_records[btrail_pkg::ADDR_W'(trail_fill)] = rec;
                        trail_fill++;
                    end
                    expected_restores.push_back(status_result(trail_fill, 1'b0));
                end
            end
            btrail_pkg::OP_REPLAY:
            begin
                if (int'(it.base_depth) >= trail_fill)
                begin
                    expected_restores.push_back(status_result(trail_fill, 1'b0));
                end
                else
                begin
                    pos        = trail_fill;
                    trail_fill = int'(it.base_depth);
                    // newest record first
                    while (pos > trail_fill)
                    begin
                        pos--;
                        rec             = saved_records[btrail_pkg::ADDR_W'(pos)];
                        r               = '0;
                        r.restore_kind  = rec.kind;
                        r.restore_index = rec.index;
                        r.restore_which = rec.which;
                        r.value_a       = rec.value_a;
                        r.value_b       = rec.value_b;
                        r.apply         = ({1'b0, rec.index} < limit_for(rec.kind));
                        r.last          = (pos == trail_fill);
                        r.depth_now     = 7'(trail_fill);
                        r.dropped       = 1'b0;
                        expected_restores.push_back(r);
                    end
                end
            end
            btrail_pkg::OP_CLEAR:
            begin
                trail_fill = 0;
                expected_restores.push_back(status_result(trail_fill, 1'b0));
            end
            default:
                expected_restores.push_back(status_result(trail_fill, 1'b0));
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of transactions from the pending queue
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        sender_step_t head;
        logic         next_valid;
        logic         next_cfg;
        if (rst_n)
        begin
            if (!item_valid && expected_restores.size() == 0)
                quiet_cycles++;
            else
                quiet_cycles = 0;

            if (!(item_valid && !item_ready) && !(cfg_valid && !cfg_ready))
            begin
                next_valid = 1'b0;
                next_cfg   = 1'b0;
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (pending_steps.size() > 0)
                begin
                    head = pending_steps[0];
                    if (head.kind == STEP_ITEM)
                    begin
                        void'(pending_steps.pop_front());
                        item_bus    <= head.payload;
                        next_valid   = 1'b1;
                        quiet_cycles = 0;
                        if (burst_left == 0)
                        begin
                            burst_left = $urandom_range(1, 40);
                            gap_left   = ($urandom_range(0, 3) == 0) ? 0
                                                                     : $urandom_range(1, 12);
                        end
                        else
                        begin
                            burst_left--;
                        end
                    end
                    else if (quiet_cycles >= QUIET_WAIT)
                    begin
                        // block is idle: config write or end of a pause
                        void'(pending_steps.pop_front());
                        if (head.kind == STEP_CFG)
                        begin
                            cfg_data <= head.cfg_value;
                            next_cfg  = 1'b1;
                        end
                    end
                end
                item_valid <= next_valid;
                cfg_valid  <= next_cfg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: changing stall patterns plus one long hold-off
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!holdoff_done && items_accepted >= HOLDOFF_AT)
            begin
                holdoff_left = HOLDOFF_LEN;
                holdoff_done = 1'b1;
            end
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(8, 60);
            end
            else
            begin
                mode_left--;
            end
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                case (stall_mode)
                    0:       result_ready <= 1'b1;
                    1:       result_ready <= ($urandom_range(0, 1) != 0);
                    2:       result_ready <= (mode_left % 4 == 0);
                    default: result_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check results, then predict from accepted transactions
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        btrail_pkg::result_t want;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (expected_restores.size() == 0)
                begin
                    $error("result with no expectation: %p", result_bus);
                    fail_count++;
                end
                else
                begin
                    want = expected_restores.pop_front();
                    check_field("restore_kind", 32'(want.restore_kind),
                                32'(result_bus.restore_kind));
                    check_field("restore_index", 32'(want.restore_index),
                                32'(result_bus.restore_index));
                    check_field("restore_which", 32'(want.restore_which),
                                32'(result_bus.restore_which));
                    check_field("value_a", want.value_a, result_bus.value_a);
                    check_field("value_b", want.value_b, result_bus.value_b);
                    check_field("apply", 32'(want.apply), 32'(result_bus.apply));
                    check_field("last", 32'(want.last), 32'(result_bus.last));
                    check_field("depth_now", 32'(want.depth_now),
                                32'(result_bus.depth_now));
                    check_field("dropped", 32'(want.dropped), 32'(result_bus.dropped));
                end
            end
            if (cfg_valid && cfg_ready)
                trail_on = cfg_data;
            if (item_valid && item_ready)
            begin
                predict_restores(item_bus);
                items_accepted++;
            end
        end
    end

    // Timeout
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL backtrack_undo_trail_unit");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus plan and end of run
    // ------------------------------------------------------------------
    initial
    begin
        fail_count     = 0;
        items_accepted = 0;
        cycle_count    = 0;
        quiet_cycles   = 0;
        gap_left       = 0;
        burst_left     = 0;
        holdoff_left   = 0;
        holdoff_done   = 1'b0;
        stall_mode     = 0;
        mode_left      = 0;
        trail_fill     = 0;
        trail_on       = 1'b0;
        gen_depth      = 0;
        gen_enable     = 1'b0;
        planned_count  = 0;

        // Directed: every push kind, index limits, value extremes
        queue_cfg(1'b1);
        queue_item(make_push(btrail_pkg::OP_PUSH_COUNTER, 8'd0, 2'd0, 32'h0, 32'h0));
        queue_item(make_push(btrail_pkg::OP_PUSH_COUNTER, 8'd31, 2'd1,
                             32'hFFFF_FFFF, 32'hFFFF_FFFF));
        queue_item(make_push(btrail_pkg::OP_PUSH_COUNTER, 8'd32, 2'd3, $urandom, $urandom));
        queue_item(make_push(btrail_pkg::OP_PUSH_CAPTURE, 8'd255, btrail_pkg::WHICH_START,
                             32'hFFFF_FFFF, 32'h0));
        queue_item(make_push(btrail_pkg::OP_PUSH_CAPTURE, 8'd0, btrail_pkg::WHICH_END,
                             $urandom, $urandom));
        queue_item(make_push(btrail_pkg::OP_PUSH_CAPTURE, 8'd31, btrail_pkg::WHICH_BOTH,
                             $urandom, $urandom));
        queue_item(make_push(btrail_pkg::OP_PUSH_CAPTURE, 8'd32, 2'd3, $urandom, $urandom));
        queue_item(make_push(btrail_pkg::OP_PUSH_VARIABLE, 8'd31, 2'd0,
                             32'h0, 32'hFFFF_FFFF));
        queue_item(make_push(btrail_pkg::OP_PUSH_VARIABLE, 8'd255, 2'd1, $urandom, $urandom));
        // base above depth, base equal to depth, then a partial unwind
        queue_item(make_replay(127));
        queue_item(make_replay(9));
        queue_item(make_replay(6));
        // pushes ignored while disabled; replay still unwinds
        queue_cfg(1'b0);
        queue_item(rand_item(btrail_pkg::OP_PUSH_COUNTER));
        queue_item(rand_item(btrail_pkg::OP_PUSH_CAPTURE));
        queue_item(make_replay(4));
        queue_cfg(1'b1);
        // unknown opcodes
        queue_item(rand_item(3'd5));
        queue_item(rand_item(3'd6));
        queue_item(rand_item(3'd7));
        queue_item(make_replay(0));
        queue_item(make_replay(0));
        queue_item(make_push(btrail_pkg::OP_PUSH_VARIABLE, 8'd128, 2'd2, $urandom, $urandom));
        queue_item(rand_item(btrail_pkg::OP_CLEAR));
        queue_item(make_replay(0));
        queue_item(make_replay(64));

        // Random: mostly push runs closed by a replay, some overflow and noise
        planned_count = 0;
        fill_trail();
        while (planned_count < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 19))
                0:       fill_trail();
                1:       queue_item(rand_item(btrail_pkg::OP_CLEAR));
                2, 3:    repeat ($urandom_range(1, 4))
                             queue_item(rand_item(3'($urandom_range(0, 7))));
                4:       queue_item(make_replay($urandom_range(gen_depth, 127)));
                5:       queue_drain();
                6:       queue_cfg($urandom_range(0, 2) != 0);
                default:
                begin
                    repeat ($urandom_range(1, 12))
                        queue_item(rand_item(3'($urandom_range(0, 2))));
                    queue_item(make_replay($urandom_range(0, gen_depth)));
                end
            endcase
        end

        // Wait for the queue to empty and the block to settle
        @(posedge clk);
        while (pending_steps.size() != 0 || quiet_cycles < QUIET_WAIT)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && expected_restores.size() == 0)
            $display("PASS backtrack_undo_trail_unit");
        else
            $display("FAIL backtrack_undo_trail_unit");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/btrail_pkg.sv
rtl/btrail_ram.sv
rtl/btrail_ctrl.sv
rtl/backtrack_undo_trail_unit.sv
test/backtrack_undo_trail_unit_tb.sv
